// ===== sv/lpq_pkg.sv =====
// ============================================================================
// lpq_pkg
// Shared types, codes and default sizes for the length-prefixed ring queue.
// ============================================================================
package lpq_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int RING_DEPTH_DEF     = 1024;
   localparam int RESERVED_BYTES_DEF = 8;
   localparam int MAX_MESSAGE_DEF    = 64;

   // Every message starts with a 4-byte little-endian length prefix.
   localparam int PREFIX_BYTES = 4;

   // Fixed field widths.
   localparam int KIND_W     = 2;
   localparam int MSG_W      = 7;
   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 3;
   localparam int LEN_W      = 32;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_INDEX_W = 1;
   localparam int STEP_W     = 2;

   // Item kinds. The fourth code is unassigned and is dropped silently.
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_START = 2'd0,
      KIND_PUSH_BYTE  = 2'd1,
      KIND_POP        = 2'd2
   } kind_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_DISABLED  = 3'd1,
      STATUS_NO_SPACE  = 3'd2,
      STATUS_CORRUPT   = 3'd3,
      STATUS_SKIPPED   = 3'd4,
      STATUS_EMPTY     = 3'd5,
      STATUS_BAD_CAP   = 3'd6,
      STATUS_NO_APPEND = 3'd7
   } status_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QUEUE_ENABLED = 1'd0,
      CSR_RING_SIZE     = 1'd1
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREFIX,
      ST_HEADER,
      ST_CHECK,
      ST_SEND
   } state_type;

   // One result item.
   typedef struct packed {
      status_type        status;
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              last;
      logic [MSG_W-1:0]  popped_length;
   } rsp_type;

endpackage

// ===== sv/lpq_ram.sv =====
// ============================================================================
// lpq_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ============================================================================
module lpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/length_prefixed_ring_queue.sv =====
// ============================================================================
// length_prefixed_ring_queue
// Byte ring of runtime size holding whole messages, each stored behind a
// 4-byte little-endian length prefix. Push, append and pop are sequenced
// around one byte-wide RAM.
// ============================================================================
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ---------------------------------------
//  req      start / busy           kind, msg_length, data_byte, out_capacity
//  rsp      rsp_valid strobe       status, out_byte, byte_valid, last,
//                                  popped_length
//  csr      csr_valid / csr_ready  csr_index, csr_wdata
//
// A push_byte or an item failing its early checks is handled in the idle
// state; a prefix-storing push_start makes one RAM write per prefix byte;
// a sending pop makes 4 header reads, one length check, then
// one body byte per cycle from the RAM read port. Each result appears on
// the rsp ports the cycle after it is decided. Reset clears the indexes
// and the append state; RAM contents are kept and no clearing pass is run.
// Results cannot be stalled; busy is high while an item is in progress.
//
module length_prefixed_ring_queue #(
   parameter int RING_DEPTH     = lpq_pkg::RING_DEPTH_DEF,
   parameter int RESERVED_BYTES = lpq_pkg::RESERVED_BYTES_DEF,
   parameter int MAX_MESSAGE    = lpq_pkg::MAX_MESSAGE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Item input
   input  logic                              start,
   output logic                              busy,
   input  logic [lpq_pkg::KIND_W-1:0]        req_kind,
   input  logic [lpq_pkg::MSG_W-1:0]         req_msg_length,
   input  logic [lpq_pkg::BYTE_W-1:0]        req_data_byte,
   input  logic [lpq_pkg::MSG_W-1:0]         req_out_capacity,
   // Results
   output logic                              rsp_valid,
   output logic [lpq_pkg::STATUS_W-1:0]      rsp_status,
   output logic [lpq_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                              rsp_byte_valid,
   output logic                              rsp_last,
   output logic [lpq_pkg::MSG_W-1:0]         rsp_popped_length,
   // Configuration
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lpq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lpq_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IW = $clog2(RING_DEPTH);
   localparam int SW = $clog2(RING_DEPTH + 1);
   localparam int CW = (SW > lpq_pkg::CSR_DATA_W) ? SW : lpq_pkg::CSR_DATA_W;
   localparam int FW = ((SW > 8) ? SW : 8) + 1;
   localparam int MW = lpq_pkg::MSG_W;
   localparam int BW = lpq_pkg::BYTE_W;
   localparam int LW = lpq_pkg::LEN_W;
   localparam int PW = lpq_pkg::STEP_W;

   // Control registers.
   lpq_pkg::state_type state_ff, state_in;
   logic [IW-1:0]      head_ff, head_in;
   logic [IW-1:0]      tail_ff, tail_in;
   logic [IW-1:0]      wr_idx_ff, wr_idx_in;
   logic [MW-1:0]      remaining_ff, remaining_in;
   logic               open_ff, open_in;
   logic               enabled_ff, enabled_in;
   logic [lpq_pkg::CSR_DATA_W-1:0] ring_size_ff, ring_size_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Working registers of the item in progress.
   logic [IW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]      step_ff, step_in;
   logic [LW-1:0]      len_ff, len_in;
   logic [SW-1:0]      used_m4_ff, used_m4_in;
   logic [MW-1:0]      cap_ff, cap_in;
   logic [MW-1:0]      mlen_ff, mlen_in;
   logic [MW-1:0]      count_ff, count_in;
   lpq_pkg::rsp_type   rsp_ff, rsp_in;

   // RAM ports.
   logic               mem_we;
   logic [IW-1:0]      mem_waddr;
   logic [BW-1:0]      mem_wdata;
   logic               mem_re;
   logic [IW-1:0]      mem_raddr;
   logic [BW-1:0]      mem_rdata;

   // Decision terms.
   logic               accept;
   lpq_pkg::kind_type  req_kind_e;
   logic [SW-1:0]      size_act;
   logic               en_ok;
   logic               idx_bad;
   logic               wr_bad;
   logic               empty;
   logic [FW-1:0]      raw_free;
   logic [FW-1:0]      space_need;
   logic               space_fail;
   logic [FW-1:0]      occ_floor;
   logic [FW-1:0]      used;
   logic               used_short;
   logic               cap_zero;
   logic               go_prefix;
   logic               go_header;
   logic               len_bad;
   logic               len_over;
   logic               send_last;
   logic [SW:0]        skip_sum;
   logic [IW-1:0]      skip_head;
   logic [IW-1:0]      head_inc;
   logic [IW-1:0]      tail_inc;
   logic [IW-1:0]      wr_idx_inc;
   logic [IW-1:0]      rd_ptr_inc;

   // Advance a ring index by one, wrapping at the active size.
   function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] ptr,
                                              input logic [SW-1:0] sz);
      logic [SW-1:0] nxt;
      nxt = SW'(ptr) + SW'(1);
      return (nxt == sz) ? '0 : IW'(nxt);
   endfunction

   // The RAM holding the byte ring.
   lpq_ram #(
      .WIDTH (BW),
      .DEPTH (RING_DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign busy       = (state_ff != lpq_pkg::ST_IDLE);
   assign accept     = start && !busy;
   assign req_kind_e = lpq_pkg::kind_type'(req_kind);
   assign csr_ready  = 1'b1;

   // Active ring size: a programmed size above the RAM depth acts as the depth.
   always_comb begin
      if (CW'(ring_size_ff) > CW'(RING_DEPTH)) begin
         size_act = SW'(RING_DEPTH);
      end else begin
         size_act = SW'(ring_size_ff);
      end
   end

   // Index sanity and wrap increments.
   assign en_ok      = enabled_ff && (size_act != '0);
   assign idx_bad    = (SW'(head_ff) >= size_act) || (SW'(tail_ff) >= size_act);
   assign wr_bad     = (SW'(wr_idx_ff) >= size_act);
   assign empty      = (head_ff == tail_ff);
   assign head_inc   = ring_inc(head_ff, size_act);
   assign tail_inc   = ring_inc(tail_ff, size_act);
   assign wr_idx_inc = ring_inc(wr_idx_ff, size_act);
   assign rd_ptr_inc = ring_inc(rd_ptr_ff, size_act);

   // Gap from tail round to head, before the reserve is taken off.
   always_comb begin
      if (head_ff == tail_ff) begin
         raw_free = FW'(size_act);
      end else if (head_ff > tail_ff) begin
         raw_free = FW'(head_ff) - FW'(tail_ff);
      end else begin
         raw_free = FW'(head_ff) + FW'(size_act) - FW'(tail_ff);
      end
   end

   // A push fits when its length is within the maximum and prefix, body and reserve all fit in the raw gap.
   assign space_need = FW'(lpq_pkg::PREFIX_BYTES) + FW'(RESERVED_BYTES)
                     + FW'(req_msg_length);
   assign space_fail = (req_msg_length > MW'(MAX_MESSAGE)) || (space_need > raw_free);

   // Bytes in use, seen from the pop side.
   assign occ_floor  = (raw_free > FW'(RESERVED_BYTES)) ? raw_free : FW'(RESERVED_BYTES);
   assign used       = (FW'(size_act) > occ_floor) ? FW'(size_act) - occ_floor : '0;
   assign used_short = (used < FW'(lpq_pkg::PREFIX_BYTES));
   assign cap_zero   = (req_out_capacity == '0);

   // Items that leave the idle state.
   assign go_prefix = en_ok && !idx_bad && !space_fail;
   assign go_header = !cap_zero && en_ok && !idx_bad && !empty && !used_short;

   // Stored-length checks and the head position after a skipped message.
   assign len_bad   = (len_ff == '0) || (len_ff > LW'(used_m4_ff));
   assign len_over  = (len_ff > LW'(cap_ff));
   assign skip_sum  = (SW + 1)'(rd_ptr_ff) + (SW + 1)'(len_ff[SW-1:0]);
   assign skip_head = (skip_sum >= (SW + 1)'(size_act)) ?
                      IW'(skip_sum - (SW + 1)'(size_act)) : IW'(skip_sum);
   assign send_last = (MW'(count_ff + MW'(1)) == len_ff[MW-1:0]);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpq_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_kind_e)
                  lpq_pkg::KIND_PUSH_START: begin
                     if (go_prefix) begin
                        state_in = lpq_pkg::ST_PREFIX;
                     end
                  end
                  lpq_pkg::KIND_POP: begin
                     if (go_header) begin
                        state_in = lpq_pkg::ST_HEADER;
                     end
                  end
                  default: state_in = lpq_pkg::ST_IDLE;
               endcase
            end
         end
         lpq_pkg::ST_PREFIX: begin
            if (step_ff == PW'(lpq_pkg::PREFIX_BYTES - 1)) begin
               state_in = lpq_pkg::ST_IDLE;
            end
         end
         lpq_pkg::ST_HEADER: begin
            if (step_ff == PW'(lpq_pkg::PREFIX_BYTES - 1)) begin
               state_in = lpq_pkg::ST_CHECK;
            end
         end
         lpq_pkg::ST_CHECK: begin
            if (len_bad || len_over) begin
               state_in = lpq_pkg::ST_IDLE;
            end else begin
               state_in = lpq_pkg::ST_SEND;
            end
         end
         lpq_pkg::ST_SEND: begin
            if (send_last) begin
               state_in = lpq_pkg::ST_IDLE;
            end
         end
         default: state_in = lpq_pkg::ST_IDLE;
      endcase
   end

   // Datapath, RAM accesses and results.
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      wr_idx_in    = wr_idx_ff;
      remaining_in = remaining_ff;
      open_in      = open_ff;
      rd_ptr_in    = rd_ptr_ff;
      step_in      = step_ff;
      len_in       = len_ff;
      used_m4_in   = used_m4_ff;
      cap_in       = cap_ff;
      mlen_in      = mlen_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = wr_idx_ff;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = rd_ptr_ff;

      // Default result shape: a single status-only item.
      rsp_in.out_byte      = '0;
      rsp_in.byte_valid    = 1'b0;
      rsp_in.last          = 1'b1;
      rsp_in.popped_length = '0;
      rsp_in.status        = lpq_pkg::STATUS_OK;

      case (state_ff)
         lpq_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_kind_e)
                  // Open a new append: check space and write the low prefix byte.
                  lpq_pkg::KIND_PUSH_START: begin
                     open_in      = 1'b0;
                     remaining_in = '0;
                     mlen_in      = req_msg_length;
                     if (!en_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = lpq_pkg::STATUS_DISABLED;
                     end else if (idx_bad) begin
                        head_in       = '0;
                        tail_in       = '0;
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = lpq_pkg::STATUS_CORRUPT;
                     end else if (space_fail) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = lpq_pkg::STATUS_NO_SPACE;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = tail_ff;
                        mem_wdata = BW'(req_msg_length);
                        wr_idx_in = tail_inc;
                        step_in   = PW'(1);
                     end
                  end
                  // Append one body byte; the last one commits the tail.
                  lpq_pkg::KIND_PUSH_BYTE: begin
                     rsp_valid_in = 1'b1;
                     if (!en_ok) begin
                        open_in       = 1'b0;
                        remaining_in  = '0;
                        rsp_in.status = lpq_pkg::STATUS_DISABLED;
                     end else if (!open_ff) begin
                        rsp_in.status = lpq_pkg::STATUS_NO_APPEND;
                     end else if (idx_bad || wr_bad) begin
                        head_in       = '0;
                        tail_in       = '0;
                        open_in       = 1'b0;
                        remaining_in  = '0;
                        rsp_in.status = lpq_pkg::STATUS_CORRUPT;
                     end else begin
                        mem_we       = 1'b1;
                        mem_waddr    = wr_idx_ff;
                        mem_wdata    = req_data_byte;
                        wr_idx_in    = wr_idx_inc;
                        remaining_in = remaining_ff - MW'(1);
                        if (remaining_ff == MW'(1)) begin
                           tail_in = wr_idx_inc;
                           open_in = 1'b0;
                        end
                     end
                  end
                  // Pop: run the early checks and read the first prefix byte.
                  lpq_pkg::KIND_POP: begin
                     if (req_out_capacity > MW'(MAX_MESSAGE)) begin
                        cap_in = MW'(MAX_MESSAGE);
                     end else begin
                        cap_in = req_out_capacity;
                     end
                     used_m4_in = SW'(used - FW'(lpq_pkg::PREFIX_BYTES));
                     if (cap_zero) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = lpq_pkg::STATUS_BAD_CAP;
                     end else if (!en_ok) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = lpq_pkg::STATUS_DISABLED;
                     end else if (idx_bad || (!empty && used_short)) begin
                        head_in       = '0;
                        tail_in       = '0;
                        open_in       = 1'b0;
                        remaining_in  = '0;
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = lpq_pkg::STATUS_CORRUPT;
                     end else if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = lpq_pkg::STATUS_EMPTY;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = head_ff;
                        rd_ptr_in = head_inc;
                        step_in   = '0;
                        len_in    = '0;
                     end
                  end
                  default: rsp_valid_in = 1'b0;
               endcase
            end
         end

         // Write the three upper prefix bytes, then commit or open the append.
         lpq_pkg::ST_PREFIX: begin
            mem_we    = 1'b1;
            mem_waddr = wr_idx_ff;
            mem_wdata = '0;
            wr_idx_in = wr_idx_inc;
            step_in   = step_ff + PW'(1);
            if (step_ff == PW'(lpq_pkg::PREFIX_BYTES - 1)) begin
               if (mlen_ff == '0) begin
                  tail_in = wr_idx_inc;
               end else begin
                  open_in      = 1'b1;
                  remaining_in = mlen_ff;
               end
               rsp_valid_in  = 1'b1;
               rsp_in.status = lpq_pkg::STATUS_OK;
            end
         end

         // Gather the prefix bytes, least significant first.
         lpq_pkg::ST_HEADER: begin
            len_in[BW*step_ff +: BW] = mem_rdata;
            step_in = step_ff + PW'(1);
            if (step_ff != PW'(lpq_pkg::PREFIX_BYTES - 1)) begin
               mem_re    = 1'b1;
               mem_raddr = rd_ptr_ff;
               rd_ptr_in = rd_ptr_inc;
            end
         end

         // Judge the stored length: clear, skip, or start sending.
         lpq_pkg::ST_CHECK: begin
            if (len_bad) begin
               head_in       = '0;
               tail_in       = '0;
               open_in       = 1'b0;
               remaining_in  = '0;
               rsp_valid_in  = 1'b1;
               rsp_in.status = lpq_pkg::STATUS_CORRUPT;
            end else if (len_over) begin
               head_in       = skip_head;
               rsp_valid_in  = 1'b1;
               rsp_in.status = lpq_pkg::STATUS_SKIPPED;
               rsp_in.popped_length = (len_ff > LW'({MW{1'b1}})) ?
                                      {MW{1'b1}} : len_ff[MW-1:0];
            end else begin
               mem_re    = 1'b1;
               mem_raddr = rd_ptr_ff;
               rd_ptr_in = rd_ptr_inc;
               count_in  = '0;
            end
         end

         // One body byte per cycle; the head moves past the message at the end.
         lpq_pkg::ST_SEND: begin
            rsp_valid_in         = 1'b1;
            rsp_in.status        = lpq_pkg::STATUS_OK;
            rsp_in.out_byte      = mem_rdata;
            rsp_in.byte_valid    = 1'b1;
            rsp_in.last          = send_last;
            rsp_in.popped_length = len_ff[MW-1:0];
            count_in             = count_ff + MW'(1);
            if (send_last) begin
               head_in = rd_ptr_ff;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = rd_ptr_ff;
               rd_ptr_in = rd_ptr_inc;
            end
         end

         default: rsp_valid_in = 1'b0;
      endcase
   end

   // Configuration writes.
   always_comb begin
      enabled_in   = enabled_ff;
      ring_size_in = ring_size_ff;
      if (csr_valid && csr_ready) begin
         case (lpq_pkg::csr_index_type'(csr_index))
            lpq_pkg::CSR_QUEUE_ENABLED: enabled_in   = csr_wdata[0];
            lpq_pkg::CSR_RING_SIZE:     ring_size_in = csr_wdata;
            default:                    enabled_in   = enabled_ff;
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpq_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         wr_idx_ff    <= '0;
         remaining_ff <= '0;
         open_ff      <= 1'b0;
         enabled_ff   <= 1'b1;
         ring_size_ff <= lpq_pkg::CSR_DATA_W'(1024);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         wr_idx_ff    <= wr_idx_in;
         remaining_ff <= remaining_in;
         open_ff      <= open_in;
         enabled_ff   <= enabled_in;
         ring_size_ff <= ring_size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      rd_ptr_ff  <= rd_ptr_in;
      step_ff    <= step_in;
      len_ff     <= len_in;
      used_m4_ff <= used_m4_in;
      cap_ff     <= cap_in;
      mlen_ff    <= mlen_in;
      count_ff   <= count_in;
      rsp_ff     <= rsp_in;
   end

   // Result ports.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_out_byte      = rsp_ff.out_byte;
   assign rsp_byte_valid    = rsp_ff.byte_valid;
   assign rsp_last          = rsp_ff.last;
   assign rsp_popped_length = rsp_ff.popped_length;

endmodule

// ===== test/tb_length_prefixed_ring_queue.sv =====
// ============================================================================
// tb_length_prefixed_ring_queue
// Self-checking bench for the length-prefixed message ring. A scoreboard
// class keeps its own copy of the ring, the indexes and the registers, and
// predicts every result of each accepted item. Results are checked field
// by field in order. Stimulus starts with a directed walk through the
// corner cases and then runs phases of random, mostly well-formed message
// traffic under several register settings.
// ============================================================================
module tb_length_prefixed_ring_queue;
   import lpq_pkg::*;

   localparam int RING_DEPTH     = RING_DEPTH_DEF;
   localparam int RESERVED_BYTES = RESERVED_BYTES_DEF;
   localparam int MAX_MESSAGE    = MAX_MESSAGE_DEF;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 20;

   // The fourth kind code has no operation behind it.
   localparam logic [KIND_W-1:0] KIND_UNASSIGNED = 2'd3;

   // ------------------------------------------------------------------------
   // Scoreboard: ring predictor plus the queue of expected result items.
   // ------------------------------------------------------------------------
   class ring_queue_scoreboard;
      bit                 enabled;
      logic [10:0]        size_reg;
      logic [BYTE_W-1:0]  store [RING_DEPTH];
      int unsigned        head;
      int unsigned        tail;
      int unsigned        windex;
      int unsigned        remaining;
      bit                 open;
      rsp_type            expected [$];
      int                 mismatches;
      int                 results_checked;
      int                 bytes_out;
      int                 skips;
      int                 clears;

      function new();
         enabled   = 1'b1;
         size_reg  = 11'd1024;
         head      = 0;
         tail      = 0;
         windex    = 0;
         remaining = 0;
         open      = 1'b0;
         mismatches = 0;
         results_checked = 0;
         bytes_out = 0;
         skips     = 0;
         clears    = 0;
         foreach (store[i]) store[i] = '0;
      endfunction

      // A ring size above the physical depth behaves as the full depth.
      function int unsigned active_size();
         return (size_reg > RING_DEPTH) ? RING_DEPTH : int'(size_reg);
      endfunction

      // Gap from tail round to head, less the reserve, never negative.
      function int unsigned free_space(int unsigned sz);
         int unsigned f;
         if (head == tail) f = sz;
         else if (head > tail) f = head - tail;
         else f = head + (sz - tail);
         return (f > RESERVED_BYTES) ? f - RESERVED_BYTES : 0;
      endfunction

      function void clear_ring();
         head      = 0;
         tail      = 0;
         open      = 1'b0;
         remaining = 0;
         clears++;
      endfunction

      function void add_result(status_type st, logic [BYTE_W-1:0] b, logic v, logic l,
                               int unsigned len);
         rsp_type r;
         r.status        = st;
         r.out_byte      = b;
         r.byte_valid    = v;
         r.last          = l;
         r.popped_length = (len > 127) ? 7'd127 : len[MSG_W-1:0];
         expected.push_back(r);
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_QUEUE_ENABLED) enabled = value[0];
         else size_reg = value;
      endfunction

      // Work out every result that one accepted item causes.
      function void note_item(logic [KIND_W-1:0] kind, logic [MSG_W-1:0] mlen,
                              logic [BYTE_W-1:0] dbyte, logic [MSG_W-1:0] cap_in);
         int unsigned sz, t, h, f, used, len, cap;
         sz = active_size();
         case (kind)
            KIND_PUSH_START: begin
               // Any open append is abandoned before the new one is tried.
               open = 1'b0;
               remaining = 0;
               if (!enabled || sz == 0) begin
                  add_result(STATUS_DISABLED, '0, 1'b0, 1'b1, 0);
               end else if (head >= sz || tail >= sz) begin
                  clear_ring();
                  add_result(STATUS_CORRUPT, '0, 1'b0, 1'b1, 0);
               end else if (free_space(sz) == 0 || mlen > MAX_MESSAGE ||
                            PREFIX_BYTES + mlen > free_space(sz)) begin
                  add_result(STATUS_NO_SPACE, '0, 1'b0, 1'b1, 0);
               end else begin
                  t = tail;
                  for (int i = 0; i < PREFIX_BYTES; i++) begin
                     store[t] = (i == 0) ? {1'b0, mlen} : '0;
                     t = (t + 1) % sz;
                  end
                  windex = t;
                  // An empty body commits at once.
                  if (mlen == 0) begin
                     tail = t;
                  end else begin
                     open = 1'b1;
                     remaining = mlen;
                  end
                  add_result(STATUS_OK, '0, 1'b0, 1'b1, 0);
               end
            end
            KIND_PUSH_BYTE: begin
               if (!enabled || sz == 0) begin
                  open = 1'b0;
                  remaining = 0;
                  add_result(STATUS_DISABLED, '0, 1'b0, 1'b1, 0);
               end else if (!open) begin
                  add_result(STATUS_NO_APPEND, '0, 1'b0, 1'b1, 0);
               end else if (head >= sz || tail >= sz || windex >= sz) begin
                  clear_ring();
                  add_result(STATUS_CORRUPT, '0, 1'b0, 1'b1, 0);
               end else begin
                  store[windex] = dbyte;
                  windex = (windex + 1) % sz;
                  remaining = (remaining - 1) & 32'h7F;
                  // The tail commits on the last body byte.
                  if (remaining == 0) begin
                     tail = windex;
                     open = 1'b0;
                  end
                  add_result(STATUS_OK, '0, 1'b0, 1'b1, 0);
               end
            end
            KIND_POP: begin
               cap = (cap_in > MAX_MESSAGE) ? MAX_MESSAGE : cap_in;
               if (cap_in == 0) begin
                  add_result(STATUS_BAD_CAP, '0, 1'b0, 1'b1, 0);
               end else if (!enabled || sz == 0) begin
                  add_result(STATUS_DISABLED, '0, 1'b0, 1'b1, 0);
               end else if (head >= sz || tail >= sz) begin
                  clear_ring();
                  add_result(STATUS_CORRUPT, '0, 1'b0, 1'b1, 0);
               end else if (head == tail) begin
                  add_result(STATUS_EMPTY, '0, 1'b0, 1'b1, 0);
               end else begin
                  f = free_space(sz) + RESERVED_BYTES;
                  used = (sz > f) ? sz - f : 0;
                  h = head;
                  len = 0;
                  for (int i = 0; i < PREFIX_BYTES; i++) begin
                     len = len | ({24'd0, store[h]} << (8 * i));
                     h = (h + 1) % sz;
                  end
                  if (used < PREFIX_BYTES || len == 0 || len > used - PREFIX_BYTES) begin
                     clear_ring();
                     add_result(STATUS_CORRUPT, '0, 1'b0, 1'b1, 0);
                  end else if (len > cap) begin
                     // Too long for the receiver: step over the whole message.
                     head = (h + len) % sz;
                     skips++;
                     add_result(STATUS_SKIPPED, '0, 1'b0, 1'b1, len);
                  end else begin
                     for (int unsigned i = 0; i < len; i++) begin
                        add_result(STATUS_OK, store[h], 1'b1, (i + 1 == len), len);
                        h = (h + 1) % sz;
                     end
                     head = h;
                     bytes_out += len;
                  end
               end
            end
            default: begin
               // Unassigned kind: no result and no state change.
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         mismatches++;
      endtask

      // Compare one observed result item with the oldest expectation.
      task check_result(rsp_type got);
         rsp_type want;
         if (expected.size() == 0) begin
            report_mismatch($sformatf("result with nothing outstanding, status %0d",
                                      got.status));
         end else begin
            want = expected.pop_front();
            results_checked++;
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
            if (got.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %0h, wanted %0h",
                                         got.out_byte, want.out_byte));
            if (got.byte_valid !== want.byte_valid)
               report_mismatch($sformatf("byte_valid %0b, wanted %0b",
                                         got.byte_valid, want.byte_valid));
            if (got.last !== want.last)
               report_mismatch($sformatf("last %0b, wanted %0b", got.last, want.last));
            if (got.popped_length !== want.popped_length)
               report_mismatch($sformatf("popped_length %0d, wanted %0d",
                                         got.popped_length, want.popped_length));
         end
      endtask
   endclass

   // ------------------------------------------------------------------------
   // Signals and the block under test.
   // ------------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [KIND_W-1:0]      req_kind = '0;
   logic [MSG_W-1:0]       req_msg_length = '0;
   logic [BYTE_W-1:0]      req_data_byte = '0;
   logic [MSG_W-1:0]       req_out_capacity = '0;
   logic                   rsp_valid;
   logic [STATUS_W-1:0]    rsp_status;
   logic [BYTE_W-1:0]      rsp_out_byte;
   logic                   rsp_byte_valid;
   logic                   rsp_last;
   logic [MSG_W-1:0]       rsp_popped_length;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   ring_queue_scoreboard sb = new();
   rsp_type              observed;
   bit                   gaps_on = 1'b1;
   int                   items_sent = 0;
   int                   unassigned_sent = 0;
   int                   settings_used = 0;
   int                   cycles = 0;

   length_prefixed_ring_queue #(
      .RING_DEPTH     (RING_DEPTH),
      .RESERVED_BYTES (RESERVED_BYTES),
      .MAX_MESSAGE    (MAX_MESSAGE)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_msg_length    (req_msg_length),
      .req_data_byte     (req_data_byte),
      .req_out_capacity  (req_out_capacity),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_last          (rsp_last),
      .rsp_popped_length (rsp_popped_length),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Clock with a 10-unit period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every strobed result is checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         observed.status        = status_type'(rsp_status);
         observed.out_byte      = rsp_out_byte;
         observed.byte_valid    = rsp_byte_valid;
         observed.last          = rsp_last;
         observed.popped_length = rsp_popped_length;
         sb.check_result(observed);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results outstanding.",
                  cycles, sb.expected.size());
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Drivers.
   // ------------------------------------------------------------------------
   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // Offer one item and hold it until the block takes it.
   task automatic send_item(logic [KIND_W-1:0] kind, logic [MSG_W-1:0] mlen,
                            logic [BYTE_W-1:0] dbyte, logic [MSG_W-1:0] cap);
      if (gaps_on && $urandom_range(0, 99) < 30) idle_cycles($urandom_range(1, 3));
      @(negedge clock);
      start            = 1'b1;
      req_kind         = kind;
      req_msg_length   = mlen;
      req_data_byte    = dbyte;
      req_out_capacity = cap;
      do @(posedge clock); while (busy);
      sb.note_item(kind, mlen, dbyte, cap);
      if (kind == KIND_UNASSIGNED) unassigned_sent++;
      else items_sent++;
   endtask

   // Wait until every result is in and the block has gone quiet.
   task automatic settle();
      idle_cycles(1);
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Change the registers at idle. A new ring size is only applied when the
   // stored messages cannot be read back through it; otherwise the queue is
   // emptied first so no pop ever reads a byte that was never written.
   task automatic apply_setting(bit en, logic [CSR_DATA_W-1:0] size);
      int unsigned newsz;
      newsz = (size > RING_DEPTH) ? RING_DEPTH : int'(size);
      settle();
      if (newsz != sb.active_size() &&
          !(sb.head >= newsz || sb.tail >= newsz ||
            (sb.head == sb.tail && (!sb.open || sb.windex >= newsz)))) begin
         if (sb.open) begin
            send_item(KIND_PUSH_START, 7'd127, $urandom_range(0, 255), $urandom_range(0, 127));
            settle();
         end
         if (sb.head != sb.tail) begin
            // A one-byte ring puts an index out of range, so the pop clears.
            write_csr(CSR_RING_SIZE, 11'd1);
            write_csr(CSR_QUEUE_ENABLED, 11'd1);
            send_item(KIND_POP, $urandom_range(0, 127), $urandom_range(0, 255), 7'd64);
            settle();
         end
      end
      write_csr(CSR_QUEUE_ENABLED, {10'd0, en});
      write_csr(CSR_RING_SIZE, size);
      settings_used++;
   endtask

   // Body lengths: mostly short, some long, a few past the maximum.
   function automatic logic [MSG_W-1:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 7'd0;
      if (r < 65) return $urandom_range(1, 8);
      if (r < 90) return $urandom_range(9, 32);
      if (r < 95) return $urandom_range(33, MAX_MESSAGE);
      return $urandom_range(MAX_MESSAGE + 1, 127);
   endfunction

   // Capacities: mostly enough for the message, some short, some zero.
   function automatic logic [MSG_W-1:0] pick_capacity();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 7'd0;
      if (r < 15) return $urandom_range(MAX_MESSAGE + 1, 127);
      if (r < 30) return $urandom_range(1, 16);
      return $urandom_range(48, MAX_MESSAGE);
   endfunction

   // One random step. Most appends run to completion as a whole message;
   // the rest leave an append open for noise and abandoned messages.
   task automatic random_item();
      int                r;
      logic [KIND_W-1:0] kind;
      logic [MSG_W-1:0]  mlen;
      logic [MSG_W-1:0]  cap;
      mlen = $urandom_range(0, 127);
      cap  = $urandom_range(0, 127);
      r    = $urandom_range(0, 99);
      if (sb.open) begin
         if (r < 85) kind = KIND_PUSH_BYTE;
         else if (r < 90) begin
            kind = KIND_PUSH_START;
            mlen = pick_length();
         end else if (r < 95) begin
            kind = KIND_POP;
            cap  = pick_capacity();
         end else kind = KIND_UNASSIGNED;
      end else begin
         if (r < 45) begin
            kind = KIND_PUSH_START;
            mlen = pick_length();
         end else if (r < 88) begin
            kind = KIND_POP;
            cap  = pick_capacity();
         end else if (r < 95) kind = KIND_PUSH_BYTE;
         else kind = KIND_UNASSIGNED;
      end
      send_item(kind, mlen, $urandom_range(0, 255), cap);
      if (kind == KIND_PUSH_START && sb.open && $urandom_range(0, 99) < 85) begin
         while (sb.open)
            send_item(KIND_PUSH_BYTE, $urandom_range(0, 127), $urandom_range(0, 255),
                      $urandom_range(0, 127));
      end
   endtask

   task automatic random_items(int n);
      int target;
      target = items_sent + n;
      while (items_sent < target) random_item();
   endtask

   task automatic run_phase(bit en, logic [CSR_DATA_W-1:0] size, int n);
      apply_setting(en, size);
      random_items(n);
   endtask

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed corner cases under the reset settings.
      send_item(KIND_POP, 7'd0, 8'h00, 7'd10);          // empty queue
      send_item(KIND_POP, 7'd127, 8'hFF, 7'd0);         // zero capacity
      send_item(KIND_PUSH_BYTE, 7'd0, 8'h3C, 7'd0);     // no open append
      send_item(KIND_PUSH_START, 7'd127, 8'h00, 7'd0);  // length far past the maximum
      send_item(KIND_PUSH_START, 7'd65, 8'h00, 7'd0);   // one past the maximum
      send_item(KIND_PUSH_START, 7'd0, 8'h00, 7'd0);    // empty message commits at once
      send_item(KIND_POP, 7'd0, 8'h00, 7'd127);         // zero stored length clears
      send_item(KIND_PUSH_START, 7'd3, 8'h00, 7'd0);
      send_item(KIND_PUSH_BYTE, 7'd0, 8'h00, 7'd0);
      send_item(KIND_PUSH_BYTE, 7'd0, 8'hFF, 7'd0);
      send_item(KIND_PUSH_BYTE, 7'd0, 8'hA5, 7'd0);
      // Abandon a half-written append by starting another.
      send_item(KIND_PUSH_START, 7'd2, 8'h00, 7'd0);
      send_item(KIND_PUSH_BYTE, 7'd0, 8'h11, 7'd0);
      send_item(KIND_PUSH_START, 7'd1, 8'h00, 7'd0);
      send_item(KIND_PUSH_BYTE, 7'd0, 8'h5A, 7'd0);
      send_item(KIND_POP, 7'd0, 8'h00, 7'd2);           // too long for the receiver
      send_item(KIND_POP, 7'd0, 8'h00, 7'd127);         // capacity above the maximum
      send_item(KIND_UNASSIGNED, 7'd127, 8'hFF, 7'd127);
      send_item(KIND_POP, 7'd0, 8'h00, 7'd64);
      send_item(KIND_PUSH_START, 7'd20, 8'h00, 7'd0);   // leave an append open

      // Shrink the ring under the open append's write index.
      apply_setting(1'b1, 11'd14);
      send_item(KIND_PUSH_BYTE, 7'd0, 8'h77, 7'd0);
      random_items(10);

      run_phase(1'b1, 11'd2047, 50);
      run_phase(1'b0, 11'd1024, 10);
      run_phase(1'b1, 11'd0, 8);
      run_phase(1'b1, 11'd40, 25);
      run_phase(1'b1, 11'd16, 10);
      run_phase(1'b1, 11'd300, 40);
      gaps_on = 1'b0;
      run_phase(1'b1, 11'd1024, 40);

      // Drain and let any late result show up.
      idle_cycles(1);
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d items plus %0d unassigned codes over %0d register settings.",
               items_sent, unassigned_sent, settings_used);
      $display("Checked %0d results: %0d bytes popped, %0d skips, %0d queue clears.",
               sb.results_checked, sb.bytes_out, sb.skips, sb.clears);
      if (sb.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/lpq_pkg.sv
sv/lpq_ram.sv
sv/length_prefixed_ring_queue.sv
test/tb_length_prefixed_ring_queue.sv
